[hw/rtl/ffdl_pkg.sv]
// Shared constants and types for the feedback fractional delay line.
package ffdl_pkg;

    localparam int DELAY_DEPTH_DEF = 4096;
    localparam int SAMPLE_BITS_DEF = 24;

    localparam int RATE_BITS  = 18;
    localparam int GAIN_BITS  = 16;
    localparam int DELAY_BITS = 16;
    localparam logic [RATE_BITS-1:0] RATE_RESET = 18'd44100;

    // Q.8 delay and position, Q0.8 interpolation point
    localparam int FRAC_BITS = 8;
    // acc carries x^3 (3*FRAC_BITS) and the doubled Hermite weights
    localparam int OUT_SHIFT = 3 * FRAC_BITS + 1;
    localparam int FB_SHIFT  = GAIN_BITS - 1;

    // ms * rate / 1000 done as (product >> 3) / 125 by reciprocal multiply
    localparam int PROD_W      = DELAY_BITS + RATE_BITS;
    localparam int DIV_PRE     = 3;
    localparam int SCALED_W    = PROD_W - DIV_PRE;
    localparam int RECIP_W     = 32;
    localparam int RECIP_SHIFT = 38;
    localparam logic [RECIP_W-1:0] RECIP_125 = 32'd2199023256;
    localparam int Q_W         = SCALED_W + RECIP_W - RECIP_SHIFT;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PROD,
        S_SCALE,
        S_POS,
        S_RD_M1,
        S_RD_0,
        S_RD_P1,
        S_RD_P2,
        S_RD_LAST,
        S_COEF,
        S_H1,
        S_H2,
        S_H3,
        S_ROUND,
        S_FB,
        S_WRITE
    } t_state;

endpackage

[hw/rtl/ffdl_ram.sv]
// Generic simple dual-port RAM with registered read.
module ffdl_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[hw/rtl/feedback_fractional_delay_line.sv]
// Feedback fractional delay line: top level with sequencer and datapath.
//
// Each transfer carries a sample, a feedback gain and a delay in ms (Q8.8). The
// delay is scaled by the sample-rate register into a Q.8 sample count, capped
// at DELAY_DEPTH-3, and four neighbors around the read point are fetched one
// per cycle from a single-read-port sample RAM and combined by a cubic Hermite
// interpolator; the output is saturated. Sample plus output times gain is
// written back at the write pointer. From its transfer to its write-back, which
// is also the edge its result appears on the output, an item passes through
// delay scaling (S_PROD to S_POS), four reads and the read latency (S_RD_M1 to
// S_RD_LAST), five interpolation stages (S_COEF to S_ROUND), gain multiply and
// write; the sequencer then returns to idle, so no new transfer is taken before
// the previous one is written back. The write waits while the previous result
// is still held on the output. The RAM needs no clearing after reset: the write
// pointer fills it in order, and entries not yet written read as zero.
module feedback_fractional_delay_line #(
    parameter int DELAY_DEPTH = ffdl_pkg::DELAY_DEPTH_DEF,
    parameter int SAMPLE_BITS = ffdl_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic [ffdl_pkg::RATE_BITS-1:0]         i_cfg_data,
    input  logic                                   i_in_valid,
    output logic                                   o_in_stall,
    input  logic signed [SAMPLE_BITS-1:0]          i_in_sample,
    input  logic signed [ffdl_pkg::GAIN_BITS-1:0]  i_feedback_gain,
    input  logic [ffdl_pkg::DELAY_BITS-1:0]        i_delay_ms,
    output logic                                   o_out_valid,
    input  logic                                   i_out_stall,
    output logic signed [SAMPLE_BITS-1:0]          o_out_sample
);

    localparam int AW    = $clog2(DELAY_DEPTH);
    localparam int FB    = ffdl_pkg::FRAC_BITS;
    localparam int DW    = AW + FB;
    localparam int MAXD  = (DELAY_DEPTH - 3) * (2 ** FB);
    localparam int SPAN  = DELAY_DEPTH * (2 ** FB);
    localparam int SB    = SAMPLE_BITS;
    localparam int CW    = SB + 4;
    localparam int T1W   = SB + 13;
    localparam int T2W   = SB + 22;
    localparam int T3W   = SB + 31;
    localparam int YW    = T3W - ffdl_pkg::OUT_SHIFT;
    localparam int PW    = SB + ffdl_pkg::GAIN_BITS;
    localparam int WW    = SB + 2;

    localparam logic signed [T3W-1:0] OUT_HALF = T3W'(64'd1 << (ffdl_pkg::OUT_SHIFT - 1));
    localparam logic signed [PW-1:0]  FB_HALF  = PW'(64'd1 << (ffdl_pkg::FB_SHIFT - 1));
    localparam logic signed [YW-1:0]  Y_MAX    = YW'((64'd1 << (SB - 1)) - 64'd1);
    localparam logic signed [YW-1:0]  Y_MIN    = -Y_MAX - YW'(1);
    localparam logic signed [WW-1:0]  W_MAX    = WW'((64'd1 << (SB - 1)) - 64'd1);
    localparam logic signed [WW-1:0]  W_MIN    = -W_MAX - WW'(1);

    ffdl_pkg::t_state r_state, n_state;

    logic [ffdl_pkg::RATE_BITS-1:0]       r_sample_rate_hz;
    logic [AW-1:0]                        r_wp;
    logic                                 r_full;
    logic                                 r_out_valid;
    logic signed [SB-1:0]                 r_out_sample;

    logic signed [SB-1:0]                 r_x_in;
    logic signed [ffdl_pkg::GAIN_BITS-1:0] r_fb;
    logic [ffdl_pkg::DELAY_BITS-1:0]      r_dms;
    logic [ffdl_pkg::PROD_W-1:0]          r_prod;
    logic [ffdl_pkg::Q_W-1:0]             r_q;
    logic [AW-1:0]                        r_im1, r_i0, r_ip1, r_ip2;
    logic [FB-1:0]                        r_x;
    logic                                 r_rd_ok;
    logic signed [SB-1:0]                 r_ym1, r_y0, r_y1, r_y2;
    logic signed [CW-1:0]                 r_a, r_b, r_c;
    logic signed [T1W-1:0]                r_t1;
    logic signed [T2W-1:0]                r_t2;
    logic signed [T3W-1:0]                r_t3;
    logic signed [SB-1:0]                 r_y;
    logic signed [PW-1:0]                 r_fbp;

    logic                                 accept;
    logic                                 out_free;
    logic                                 ram_we;
    logic [AW-1:0]                        rd_addr;
    logic [SB-1:0]                        ram_rdata;
    logic signed [SB-1:0]                 rd_data;

    logic [ffdl_pkg::SCALED_W+ffdl_pkg::RECIP_W-1:0] recip_prod;
    logic [DW-1:0]                        d_sat;
    logic [DW:0]                          pos_raw;
    logic [DW-1:0]                        pos;
    logic [AW-1:0]                        i0, im1, ip1, ip2;

    logic signed [CW-1:0]                 em1, e0, e1, e2, e01, coef_a, coef_b, coef_c;
    logic signed [FB:0]                   xs;
    logic signed [T1W-1:0]                t1;
    logic signed [T2W-1:0]                t2;
    logic signed [T3W-1:0]                t3;
    logic signed [YW-1:0]                 y_full;
    logic signed [SB-1:0]                 y_sat;
    logic signed [SB:0]                   fb_scaled;
    logic signed [WW-1:0]                 w_full;
    logic signed [SB-1:0]                 w_sat;

    assign accept   = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ffdl_pkg::S_IDLE:    if (accept) n_state = ffdl_pkg::S_PROD;
            ffdl_pkg::S_PROD:    n_state = ffdl_pkg::S_SCALE;
            ffdl_pkg::S_SCALE:   n_state = ffdl_pkg::S_POS;
            ffdl_pkg::S_POS:     n_state = ffdl_pkg::S_RD_M1;
            ffdl_pkg::S_RD_M1:   n_state = ffdl_pkg::S_RD_0;
            ffdl_pkg::S_RD_0:    n_state = ffdl_pkg::S_RD_P1;
            ffdl_pkg::S_RD_P1:   n_state = ffdl_pkg::S_RD_P2;
            ffdl_pkg::S_RD_P2:   n_state = ffdl_pkg::S_RD_LAST;
            ffdl_pkg::S_RD_LAST: n_state = ffdl_pkg::S_COEF;
            ffdl_pkg::S_COEF:    n_state = ffdl_pkg::S_H1;
            ffdl_pkg::S_H1:      n_state = ffdl_pkg::S_H2;
            ffdl_pkg::S_H2:      n_state = ffdl_pkg::S_H3;
            ffdl_pkg::S_H3:      n_state = ffdl_pkg::S_ROUND;
            ffdl_pkg::S_ROUND:   n_state = ffdl_pkg::S_FB;
            ffdl_pkg::S_FB:      n_state = ffdl_pkg::S_WRITE;
            ffdl_pkg::S_WRITE:   if (out_free) n_state = ffdl_pkg::S_IDLE;
            default:             n_state = ffdl_pkg::S_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_in_stall = 1'b1;
        ram_we     = 1'b0;
        rd_addr    = r_i0;
        unique case (r_state)
            ffdl_pkg::S_IDLE:  o_in_stall = !i_rst_n;
            ffdl_pkg::S_RD_M1: rd_addr = r_im1;
            ffdl_pkg::S_RD_0:  rd_addr = r_i0;
            ffdl_pkg::S_RD_P1: rd_addr = r_ip1;
            ffdl_pkg::S_RD_P2: rd_addr = r_ip2;
            ffdl_pkg::S_WRITE: ram_we = out_free;
            default: ;
        endcase
    end

    // delay scaling and read position
    assign recip_prod = r_prod[ffdl_pkg::PROD_W-1:ffdl_pkg::DIV_PRE] * ffdl_pkg::RECIP_125;
    assign d_sat   = (32'(r_q) > 32'(MAXD)) ? DW'(MAXD) : DW'(r_q);
    assign pos_raw = {1'b0, r_wp, {FB{1'b0}}} - {1'b0, d_sat};
    assign pos     = pos_raw[DW] ? DW'(32'(pos_raw) + 32'(SPAN)) : pos_raw[DW-1:0];
    assign i0      = pos[DW-1:FB];
    assign im1     = (i0 == '0) ? AW'(DELAY_DEPTH - 1) : i0 - 1'b1;
    assign ip1     = (i0 == AW'(DELAY_DEPTH - 1)) ? '0 : i0 + 1'b1;
    assign ip2     = (ip1 == AW'(DELAY_DEPTH - 1)) ? '0 : ip1 + 1'b1;

    // entries at or past the write pointer are unwritten until the first wrap
    assign rd_data = r_rd_ok ? ram_rdata : '0;

    // Hermite coefficients (doubled) and Horner evaluation
    assign em1    = CW'(r_ym1);
    assign e0     = CW'(r_y0);
    assign e1     = CW'(r_y1);
    assign e2     = CW'(r_y2);
    assign e01    = e0 - e1;
    assign coef_a = e1 - em1;
    assign coef_b = (em1 <<< 1) - ((e0 <<< 2) + e0) + (e1 <<< 2) - e2;
    assign coef_c = (e2 - em1) + (e01 <<< 1) + e01;
    assign xs     = signed'({1'b0, r_x});

    assign t1 = r_c * xs + (T1W'(r_b) <<< FB);
    assign t2 = r_t1 * xs + (T2W'(r_a) <<< (2 * FB));
    assign t3 = r_t2 * xs + (T3W'(r_y0) <<< ffdl_pkg::OUT_SHIFT);

    assign y_full = YW'((r_t3 + OUT_HALF) >>> ffdl_pkg::OUT_SHIFT);
    assign y_sat  = (y_full > Y_MAX) ? SB'(Y_MAX) :
                    (y_full < Y_MIN) ? SB'(Y_MIN) : y_full[SB-1:0];

    assign fb_scaled = (SB + 1)'((r_fbp + FB_HALF) >>> ffdl_pkg::FB_SHIFT);
    assign w_full    = WW'(fb_scaled) + WW'(r_x_in);
    assign w_sat     = (w_full > W_MAX) ? SB'(W_MAX) :
                       (w_full < W_MIN) ? SB'(W_MIN) : w_full[SB-1:0];

    ffdl_ram #(
        .WIDTH (SB),
        .DEPTH (DELAY_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_wp),
        .i_wdata (w_sat),
        .i_raddr (rd_addr),
        .o_rdata (ram_rdata)
    );

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state          <= ffdl_pkg::S_IDLE;
            r_sample_rate_hz <= ffdl_pkg::RATE_RESET;
            r_wp             <= '0;
            r_full           <= 1'b0;
            r_out_valid      <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_sample_rate_hz <= i_cfg_data;
            end
            if (ram_we) begin
                r_out_valid <= 1'b1;
                if (r_wp == AW'(DELAY_DEPTH - 1)) begin
                    r_wp   <= '0;
                    r_full <= 1'b1;
                end else begin
                    r_wp <= r_wp + 1'b1;
                end
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_x_in <= i_in_sample;
            r_fb   <= i_feedback_gain;
            r_dms  <= i_delay_ms;
        end
        r_rd_ok <= r_full || (rd_addr < r_wp);
        unique case (r_state)
            ffdl_pkg::S_PROD:    r_prod <= ffdl_pkg::PROD_W'(r_dms * r_sample_rate_hz);
            ffdl_pkg::S_SCALE:   r_q <= recip_prod[ffdl_pkg::RECIP_SHIFT +: ffdl_pkg::Q_W];
            ffdl_pkg::S_POS: begin
                r_im1 <= im1;
                r_i0  <= i0;
                r_ip1 <= ip1;
                r_ip2 <= ip2;
                r_x   <= pos[FB-1:0];
            end
            ffdl_pkg::S_RD_0:    r_ym1 <= rd_data;
            ffdl_pkg::S_RD_P1:   r_y0 <= rd_data;
            ffdl_pkg::S_RD_P2:   r_y1 <= rd_data;
            ffdl_pkg::S_RD_LAST: r_y2 <= rd_data;
            ffdl_pkg::S_COEF: begin
                r_a <= coef_a;
                r_b <= coef_b;
                r_c <= coef_c;
            end
            ffdl_pkg::S_H1:      r_t1 <= t1;
            ffdl_pkg::S_H2:      r_t2 <= t2;
            ffdl_pkg::S_H3:      r_t3 <= t3;
            ffdl_pkg::S_ROUND:   r_y <= y_sat;
            ffdl_pkg::S_FB:      r_fbp <= r_y * r_fb;
            ffdl_pkg::S_WRITE:   if (out_free) r_out_sample <= r_y;
            default: ;
        endcase
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_sample = r_out_sample;

endmodule
